// File: rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the stereo biquad cascade equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbq_pkg;

   localparam int NUM_BANDS_DEF      = 10;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 28;

   localparam int COEF_W    = 32;
   localparam int NUM_SLOTS = 5;
   localparam int SLOT_W    = 3;
   localparam int BAND_W    = 4;
   localparam int TAP_W     = 3;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_COEF   = 1'b1
   } opcode_type;

   // Coefficient slots and the matching multiply taps of a section.
   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_END = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAC  = 3'b010,
      ST_WB   = 3'b100
   } cell_state_type;

   // Status handed from each cell to the top level.
   typedef struct packed {
      logic busy;
      logic done;
   } cell_status_type;

endpackage

`default_nettype wire

// File: rtl/sbq_ifs.sv
// ----------------------------------------------------------------------------
// sbq channel interfaces
// Valid/ready channels for request words, response words and the mask port.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbq_req_if #(parameter int SAMPLE_BITS = sbq_pkg::SAMPLE_BITS_DEF);
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic signed [SAMPLE_BITS-1:0]  left_in;
   logic signed [SAMPLE_BITS-1:0]  right_in;
   logic                           frame_last;
   logic [sbq_pkg::BAND_W-1:0]     coef_band;
   logic [sbq_pkg::SLOT_W-1:0]     coef_slot;
   logic signed [sbq_pkg::COEF_W-1:0] coef_value;

   modport source (output valid, opcode, left_in, right_in, frame_last,
                   coef_band, coef_slot, coef_value, input ready);
   modport sink   (input valid, opcode, left_in, right_in, frame_last,
                   coef_band, coef_slot, coef_value, output ready);
endinterface

interface sbq_rsp_if #(parameter int SAMPLE_BITS = sbq_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          out_last;

   modport source (output valid, left_out, right_out, out_last, input ready);
   modport sink   (input valid, left_out, right_out, out_last, output ready);
endinterface

interface sbq_csr_if #(parameter int NUM_BANDS = sbq_pkg::NUM_BANDS_DEF);
   logic                 valid;
   logic                 ready;
   logic [NUM_BANDS-1:0] band_enable_mask;

   modport source (output valid, band_enable_mask, input ready);
   modport sink   (input valid, band_enable_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/sbq_cell.sv
// ----------------------------------------------------------------------------
// sbq_cell
// One biquad band: coefficients, per-channel history and a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_cell #(
   parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              band_en,
   input  wire logic                              coef_we,
   input  wire logic [sbq_pkg::SLOT_W-1:0]        coef_slot,
   input  wire logic signed [sbq_pkg::COEF_W-1:0] coef_value,
   input  wire logic                              in_valid,
   input  wire logic signed [SAMPLE_BITS-1:0]     in_left,
   input  wire logic signed [SAMPLE_BITS-1:0]     in_right,
   input  wire logic                              in_last,
   output logic                                   out_valid,
   output logic signed [SAMPLE_BITS-1:0]          out_left,
   output logic signed [SAMPLE_BITS-1:0]          out_right,
   output logic                                   out_last,
   output sbq_pkg::cell_status_type               status
);
   import sbq_pkg::*;

   localparam int PROD_W = COEF_W + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] YMAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] YMIN = -(ACC_W'(1) <<< (SAMPLE_BITS - 1));
   localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) <<< COEF_FRAC_BITS;

   cell_state_type                 state_ff, state_in;
   logic [TAP_W-1:0]               tap_ff, tap_in;
   logic                           ch_ff, ch_in;
   logic signed [COEF_W-1:0]       coef_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0]  x1_ff [2];
   logic signed [SAMPLE_BITS-1:0]  x2_ff [2];
   logic signed [SAMPLE_BITS-1:0]  y1_ff [2];
   logic signed [SAMPLE_BITS-1:0]  y2_ff [2];
   logic signed [SAMPLE_BITS-1:0]  l_ff, r_ff;
   logic                           last_ff;
   logic                           oval_ff, oval_in;
   logic signed [PROD_W-1:0]       prod_ff;
   logic                           neg_ff;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;

   logic signed [COEF_W-1:0]       coef_sel;
   logic signed [SAMPLE_BITS-1:0]  op_sel;
   logic signed [SAMPLE_BITS-1:0]  x_cur;
   logic signed [PROD_W-1:0]       prod_in;
   logic signed [ACC_W-1:0]        term;
   logic signed [ACC_W-1:0]        rnd_sum;
   logic signed [ACC_W-1:0]        shifted;
   logic signed [SAMPLE_BITS-1:0]  y_sat;

   assign x_cur = ch_ff ? r_ff : l_ff;

   always_comb begin
      case (tap_ff)
         SLOT_B0: begin coef_sel = coef_ff[0]; op_sel = x_cur;        end
         SLOT_B1: begin coef_sel = coef_ff[1]; op_sel = x1_ff[ch_ff]; end
         SLOT_B2: begin coef_sel = coef_ff[2]; op_sel = x2_ff[ch_ff]; end
         SLOT_A1: begin coef_sel = coef_ff[3]; op_sel = y1_ff[ch_ff]; end
         SLOT_A2: begin coef_sel = coef_ff[4]; op_sel = y2_ff[ch_ff]; end
         default: begin coef_sel = '0;         op_sel = '0;           end
      endcase
   end

   assign prod_in = PROD_W'(coef_sel) * PROD_W'(op_sel);
   assign term    = neg_ff ? -{{3{prod_ff[PROD_W-1]}}, prod_ff}
                           :  {{3{prod_ff[PROD_W-1]}}, prod_ff};
   assign rnd_sum = acc_ff + RND;
   assign shifted = rnd_sum >>> COEF_FRAC_BITS;

   always_comb begin
      if (shifted > YMAX) begin
         y_sat = YMAX[SAMPLE_BITS-1:0];
      end else if (shifted < YMIN) begin
         y_sat = YMIN[SAMPLE_BITS-1:0];
      end else begin
         y_sat = shifted[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      ch_in    = ch_ff;
      oval_in  = 1'b0;
      acc_in   = (tap_ff == SLOT_B0) ? '0 : acc_ff + term;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (band_en) begin
                  state_in = ST_MAC;
                  tap_in   = SLOT_B0;
                  ch_in    = 1'b0;
               end else begin
                  oval_in = 1'b1;
               end
            end
         end
         ST_MAC: begin
            if (tap_ff == SLOT_END) begin
               state_in = ST_WB;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         ST_WB: begin
            tap_in = SLOT_B0;
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = ST_MAC;
            end else begin
               state_in = ST_IDLE;
               oval_in  = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= SLOT_B0;
         ch_ff    <= 1'b0;
         oval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         ch_ff    <= ch_in;
         oval_ff  <= oval_in;
      end
   end

   // Multiplier and accumulator: one product per cycle, each summed in the cycle after.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= (tap_ff == SLOT_A1) || (tap_ff == SLOT_A2);
      if (state_ff == ST_MAC) begin
         acc_ff <= acc_in;
      end
   end

   // Sample registers: loaded on arrival, replaced by each channel's result.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && in_valid) begin
         l_ff    <= in_left;
         r_ff    <= in_right;
         last_ff <= in_last;
      end else if (state_ff == ST_WB) begin
         if (ch_ff) begin
            r_ff <= y_sat;
         end else begin
            l_ff <= y_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            coef_ff[i] <= (i == 0) ? ONE : '0;
         end
         for (int c = 0; c < 2; c++) begin
            x1_ff[c] <= '0;
            x2_ff[c] <= '0;
            y1_ff[c] <= '0;
            y2_ff[c] <= '0;
         end
      end else begin
         if (coef_we) begin
            case (coef_slot)
               SLOT_B0: coef_ff[0] <= coef_value;
               SLOT_B1: coef_ff[1] <= coef_value;
               SLOT_B2: coef_ff[2] <= coef_value;
               SLOT_A1: coef_ff[3] <= coef_value;
               SLOT_A2: coef_ff[4] <= coef_value;
               default: ;
            endcase
         end
         if (state_ff == ST_WB) begin
            x2_ff[ch_ff] <= x1_ff[ch_ff];
            x1_ff[ch_ff] <= x_cur;
            y2_ff[ch_ff] <= y1_ff[ch_ff];
            y1_ff[ch_ff] <= y_sat;
         end
      end
   end

   assign out_valid   = oval_ff;
   assign out_left    = l_ff;
   assign out_right   = r_ff;
   assign out_last    = last_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = oval_ff;

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= SLOT_END) else $error("tap counter out of range");
   a_wb_after_mac: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WB |-> $past(state_ff == ST_MAC && tap_ff == SLOT_END))
      else $error("write-back without full accumulation");
   a_no_input_busy: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> state_ff == ST_IDLE) else $error("word arrived while busy");

endmodule

`default_nettype wire

// File: rtl/stereo_biquad_cascade_eq_unit.sv
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_eq_unit
// Stereo equalizer: a chain of direct-form-I biquad band cells.
// ----------------------------------------------------------------------------
// Usage. Request words arrive on req_ch. A sample word (opcode 0) carries a
// left and a right sample; it runs down the chain of band cells, band 0
// first, and gives one response word on rsp_ch. A coefficient word (opcode
// 1) loads one Q3.28 coefficient of one band in the cycle it is accepted and
// gives no response; writes to a band or slot out of range are dropped.
// The csr_ch port writes the band enable mask and is always ready; it is to
// be written only while the block is idle.
//
// Flow. An enabled band picks up the word in its idle state and then uses its
// own multiplier for each channel in turn, left first (5 products, the last
// sum, one write-back); a disabled band passes the word on through its output
// register. The chain output waits in a pending register and moves from there
// into the output register. One sample word is in flight at a time; the next
// request is taken once the result has moved into the output register, even
// while it still waits there.
//
// Reset loads every band with the identity filter (b0 = 1.0), clears all
// history and enables every band. A stalled receiver holds the response word;
// the pending register then holds the finished word until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_biquad_cascade_eq_unit #(
   parameter int NUM_BANDS      = sbq_pkg::NUM_BANDS_DEF,
   parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sbq_req_if.sink   req_ch,
   sbq_rsp_if.source rsp_ch,
   sbq_csr_if.sink   csr_ch
);
   import sbq_pkg::*;

   logic [NUM_BANDS-1:0]          mask_ff;
   logic                          busy_ff;
   logic                          pend_ff;
   logic signed [SAMPLE_BITS-1:0] pend_l_ff, pend_r_ff;
   logic                          pend_last_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_l_ff, rsp_r_ff;
   logic                          rsp_last_ff;

   logic                          req_fire;
   logic                          start;
   logic                          coef_wr;
   logic                          move;

   // Chain links: link k feeds cell k, link NUM_BANDS is the chain output.
   logic                          lk_valid [NUM_BANDS+1];
   logic signed [SAMPLE_BITS-1:0] lk_left  [NUM_BANDS+1];
   logic signed [SAMPLE_BITS-1:0] lk_right [NUM_BANDS+1];
   logic                          lk_last  [NUM_BANDS+1];
   cell_status_type               cell_st  [NUM_BANDS];
   logic [NUM_BANDS-1:0]          cell_busy;

   assign req_ch.ready = !busy_ff;
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign start        = req_fire && (req_ch.opcode == OP_SAMPLE);
   assign coef_wr      = req_fire && (req_ch.opcode == OP_COEF);
   assign move         = pend_ff && (!rsp_valid_ff || rsp_ch.ready);

   assign lk_valid[0] = start;
   assign lk_left[0]  = req_ch.left_in;
   assign lk_right[0] = req_ch.right_in;
   assign lk_last[0]  = req_ch.frame_last;

   for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
      sbq_cell #(
         .SAMPLE_BITS    (SAMPLE_BITS),
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .band_en    (mask_ff[b]),
         .coef_we    (coef_wr && (req_ch.coef_band == BAND_W'(b))),
         .coef_slot  (req_ch.coef_slot),
         .coef_value (req_ch.coef_value),
         .in_valid   (lk_valid[b]),
         .in_left    (lk_left[b]),
         .in_right   (lk_right[b]),
         .in_last    (lk_last[b]),
         .out_valid  (lk_valid[b+1]),
         .out_left   (lk_left[b+1]),
         .out_right  (lk_right[b+1]),
         .out_last   (lk_last[b+1]),
         .status     (cell_st[b])
      );
      assign cell_busy[b] = cell_st[b].busy || cell_st[b].done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            mask_ff <= csr_ch.band_enable_mask;
         end
         if (start) begin
            busy_ff <= 1'b1;
         end else if (move) begin
            busy_ff <= 1'b0;
         end
         if (lk_valid[NUM_BANDS]) begin
            pend_ff <= 1'b1;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lk_valid[NUM_BANDS]) begin
         pend_l_ff    <= lk_left[NUM_BANDS];
         pend_r_ff    <= lk_right[NUM_BANDS];
         pend_last_ff <= lk_last[NUM_BANDS];
      end
      if (move) begin
         rsp_l_ff    <= pend_l_ff;
         rsp_r_ff    <= pend_r_ff;
         rsp_last_ff <= pend_last_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_l_ff;
   assign rsp_ch.right_out = rsp_r_ff;
   assign rsp_ch.out_last  = rsp_last_ff;

   // Only one cell works on the word in flight.
   a_one_cell: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_busy)) else $error("more than one band cell active");
   a_chain_needs_busy: assert property (@(posedge clock) disable iff (reset)
      lk_valid[NUM_BANDS] |-> busy_ff && !pend_ff)
      else $error("chain output without a word in flight");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("sample word accepted but not tracked");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (cell_busy == '0) && !pend_ff)
      else $error("cells active while idle");

endmodule

`default_nettype wire
